>>> rtl/core/sdv_pkg.sv
// Shared constants, register indexes and types for the stress divergence stencil.
// No dependencies.
`default_nettype none
package sdv_pkg;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int SIZE_X_W   = 11;
	localparam int SIZE_YZ_W  = 7;
	localparam int FORCE_W    = 35;
	localparam int QDEPTH     = 4;

	localparam int DEF_MAX_NX      = 1024;
	localparam int DEF_MAX_NY      = 64;
	localparam int DEF_MAX_NZ      = 64;
	localparam int DEF_STRESS_BITS = 32;

	localparam logic [CFG_IDX_W-1:0] IDX_SOLID  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] IDX_SIZE_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] IDX_SIZE_Y = 2'd2;
	localparam logic [CFG_IDX_W-1:0] IDX_SIZE_Z = 2'd3;

	localparam logic [SIZE_X_W-1:0]  RST_SIZE_X  = 11'd8;
	localparam logic [SIZE_YZ_W-1:0] RST_SIZE_YZ = 7'd8;

	typedef struct packed {
		logic                 solid;
		logic [SIZE_X_W-1:0]  size_x;
		logic [SIZE_YZ_W-1:0] size_y;
		logic [SIZE_YZ_W-1:0] size_z;
		logic                 restart;
	} cfg_t;

	typedef struct packed {
		logic pos_origin;
	} front_stat_t;
endpackage
`default_nettype wire

>>> rtl/core/sdv_ifs.sv
// Stream interfaces: lattice sites in, forces out.
// Depends on sdv_pkg.
`default_nettype none
interface sdv_site_if #(parameter int SB = sdv_pkg::DEF_STRESS_BITS);
	logic                 valid;
	logic                 ready;
	logic signed [SB-1:0] s_xx, s_xy, s_xz, s_yx, s_yy, s_yz, s_zx, s_zy, s_zz;
	logic                 is_fluid;
	modport source(output valid, s_xx, s_xy, s_xz, s_yx, s_yy, s_yz, s_zx, s_zy, s_zz,
		is_fluid, input ready);
	modport sink(input valid, s_xx, s_xy, s_xz, s_yx, s_yy, s_yz, s_zx, s_zy, s_zz,
		is_fluid, output ready);
endinterface

interface sdv_force_if;
	import sdv_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [FORCE_W-1:0] force_x, force_y, force_z;
	logic                      last_site;
	modport source(output valid, force_x, force_y, force_z, last_site, input ready);
	modport sink(input valid, force_x, force_y, force_z, last_site, output ready);
endinterface
`default_nettype wire

>>> rtl/core/sdv_delay.sv
// Variable-length delay line in a circular memory, advancing on each transfer.
// No dependencies.
`default_nettype none
module sdv_delay #(
	parameter int DEPTH = 2,
	parameter int W     = 8,
	parameter int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            clr,
	input  wire logic [PTRW-1:0] last,
	input  wire logic [W-1:0]    din,
	output logic      [W-1:0]    dout
);
	logic [W-1:0]    mem [DEPTH];
	logic [PTRW-1:0] ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (clr) begin
			ptr_q <= '0;
		end else if (en) begin
			ptr_q <= (ptr_q == last) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout     <= mem[ptr_q];
			mem[ptr_q] <= din;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/sdv_front.sv
// Front end: site counters, plane and line delay lines, neighbour gather and masking.
// Depends on sdv_pkg, sdv_ifs, sdv_delay.
`default_nettype none
module sdv_front #(
	parameter int MAX_NX      = sdv_pkg::DEF_MAX_NX,
	parameter int MAX_NY      = sdv_pkg::DEF_MAX_NY,
	parameter int MAX_NZ      = sdv_pkg::DEF_MAX_NZ,
	parameter int STRESS_BITS = sdv_pkg::DEF_STRESS_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire sdv_pkg::cfg_t         cfg,
	sdv_site_if.sink                   sites,
	input  wire logic                  q_full,
	output logic                       push,
	output logic [2:0][2:0][1:0][STRESS_BITS-1:0] taps,
	output logic                       last,
	output sdv_pkg::front_stat_t       stat
);
	import sdv_pkg::*;

	localparam int SB        = STRESS_BITS;
	localparam int W         = 9 * SB + 1;
	localparam int XW        = $clog2(MAX_NX + 3);
	localparam int YW        = $clog2(MAX_NY + 3);
	localparam int ZW        = $clog2(MAX_NZ + 3);
	localparam int PLANE_MAX = (MAX_NY + 2) * (MAX_NZ + 2);
	localparam int PW        = $clog2(PLANE_MAX + 1);
	localparam int DEP_P     = PLANE_MAX - (MAX_NZ + 2) - 1;
	localparam int DEP_L     = MAX_NZ;
	localparam int PTR_P     = (DEP_P > 1) ? $clog2(DEP_P) : 1;
	localparam int PTR_L     = (DEP_L > 1) ? $clog2(DEP_L) : 1;

	logic [XW-1:0] nx, pos_x_q;
	logic [YW-1:0] ny, ly, pos_y_q;
	logic [ZW-1:0] nz, lz, pos_z_q;
	logic [PW-1:0] plane, last_p;
	logic [ZW-1:0] last_l;
	logic          en, interior;
	logic [W-1:0]  site_w, a_out, b_out, c_out, e_out, r1_q, r2_q;

	always_comb begin
		if (cfg.size_x == '0)                       nx = XW'(1);
		else if (32'(cfg.size_x) > 32'(MAX_NX))     nx = XW'(MAX_NX);
		else                                        nx = XW'(cfg.size_x);
		if (cfg.size_y == '0)                       ny = YW'(1);
		else if (32'(cfg.size_y) > 32'(MAX_NY))     ny = YW'(MAX_NY);
		else                                        ny = YW'(cfg.size_y);
		if (cfg.size_z == '0)                       nz = ZW'(1);
		else if (32'(cfg.size_z) > 32'(MAX_NZ))     nz = ZW'(MAX_NZ);
		else                                        nz = ZW'(cfg.size_z);
	end

	assign ly     = ny + YW'(2);
	assign lz     = nz + ZW'(2);
	assign plane  = PW'(ly) * PW'(lz);
	assign last_p = plane - PW'(lz) - PW'(2);
	assign last_l = lz - ZW'(3);

	assign sites.ready = !q_full;
	assign en          = sites.valid && !q_full;
	assign site_w      = {sites.is_fluid, sites.s_zz, sites.s_zy, sites.s_zx, sites.s_yz,
		sites.s_yy, sites.s_yx, sites.s_xz, sites.s_xy, sites.s_xx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (cfg.restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (en) begin
			if (pos_z_q == lz - ZW'(1)) begin
				pos_z_q <= '0;
				if (pos_y_q == ly - YW'(1)) begin
					pos_y_q <= '0;
					pos_x_q <= (pos_x_q == nx + XW'(1)) ? '0 : pos_x_q + XW'(1);
				end else begin
					pos_y_q <= pos_y_q + YW'(1);
				end
			end else begin
				pos_z_q <= pos_z_q + ZW'(1);
			end
		end
	end

	sdv_delay #(.DEPTH(DEP_P), .W(W)) u_dly_a (
		.clk, .arst_n, .en, .clr(cfg.restart), .last(last_p[PTR_P-1:0]),
		.din(site_w), .dout(a_out));
	sdv_delay #(.DEPTH(DEP_L), .W(W)) u_dly_b (
		.clk, .arst_n, .en, .clr(cfg.restart), .last(last_l[PTR_L-1:0]),
		.din(a_out), .dout(b_out));

	always_ff @(posedge clk) begin
		if (en) begin
			r1_q <= b_out;
			r2_q <= r1_q;
		end
	end

	sdv_delay #(.DEPTH(DEP_L), .W(W)) u_dly_c (
		.clk, .arst_n, .en, .clr(cfg.restart), .last(last_l[PTR_L-1:0]),
		.din(r2_q), .dout(c_out));
	sdv_delay #(.DEPTH(DEP_P), .W(W)) u_dly_e (
		.clk, .arst_n, .en, .clr(cfg.restart), .last(last_p[PTR_P-1:0]),
		.din(c_out), .dout(e_out));

	// neighbours of the centre site: [d][minus/plus]
	logic [2:0][1:0][W-1:0] nb;
	assign nb[0][0] = e_out;
	assign nb[0][1] = site_w;
	assign nb[1][0] = c_out;
	assign nb[1][1] = a_out;
	assign nb[2][0] = r2_q;
	assign nb[2][1] = b_out;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int d = 0; d < 3; d++) begin
				for (int s = 0; s < 2; s++) begin
					if (cfg.solid && !nb[d][s][9*SB])
						taps[a][d][s] = '0;
					else
						taps[a][d][s] = nb[d][s][(3*d+a)*SB +: SB];
				end
			end
		end
	end

	assign interior = (pos_x_q >= XW'(2)) && (pos_y_q >= YW'(1)) && (pos_y_q <= ny)
		&& (pos_z_q >= ZW'(1)) && (pos_z_q <= nz);
	assign push = en && interior;
	assign last = (pos_x_q == nx + XW'(1)) && (pos_y_q == ny) && (pos_z_q == nz);
	assign stat.pos_origin = (pos_x_q == '0) && (pos_y_q == '0) && (pos_z_q == '0);
endmodule
`default_nettype wire

>>> rtl/core/sdv_queue.sv
// Short FIFO between front and back.
// Depends on sdv_pkg.
`default_nettype none
module sdv_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              full,
	output logic              nempty,
	output logic [$clog2(sdv_pkg::QDEPTH+1)-1:0] count
);
	import sdv_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	logic [W-1:0]  ent_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [$clog2(QDEPTH+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= wdata;
	end

	assign rdata  = ent_q[rd_q];
	assign full   = (cnt_q == ($clog2(QDEPTH+1))'(QDEPTH));
	assign nempty = (cnt_q != '0);
	assign count  = cnt_q;
endmodule
`default_nettype wire

>>> rtl/core/sdv_back.sv
// Back end: sums neighbour stress differences into the force output register.
// Depends on sdv_pkg, sdv_ifs.
`default_nettype none
module sdv_back #(
	parameter int STRESS_BITS = sdv_pkg::DEF_STRESS_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   nempty,
	input  wire logic [2:0][2:0][1:0][STRESS_BITS-1:0]  taps,
	input  wire logic                                   last,
	output logic                                        pop,
	sdv_force_if.source                                 forces
);
	import sdv_pkg::*;

	localparam int SB = STRESS_BITS;
	localparam int AW = ((SB > FORCE_W) ? SB : FORCE_W) + 3;

	logic              ov_q;
	logic [2:0][AW-1:0] acc;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			acc[a] = '0;
			for (int d = 0; d < 3; d++) begin
				acc[a] = acc[a] + {{(AW-SB){taps[a][d][0][SB-1]}}, taps[a][d][0]}
					- {{(AW-SB){taps[a][d][1][SB-1]}}, taps[a][d][1]};
			end
		end
	end

	assign pop = nempty && (!ov_q || forces.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop) begin
			ov_q <= 1'b1;
		end else if (forces.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			forces.force_x   <= acc[0][FORCE_W-1:0];
			forces.force_y   <= acc[1][FORCE_W-1:0];
			forces.force_z   <= acc[2][FORCE_W-1:0];
			forces.last_site <= last;
		end
	end

	assign forces.valid = ov_q;
endmodule
`default_nettype wire

>>> rtl/core/stress_divergence_stencil.sv
// Seven-point stress divergence stencil, top level.
// A force is registered in a queue entry when its +x neighbour site transfers, then in the
// output register when the queue pops; a stall can delay it.
// Throughput: one site per cycle while the queue is not full; the plane and line delay
// memories do one read and one write per transfer. Reset clears counters, queue and output
// valid; the delay memories are not cleared. Sizes reset to 8, solid masking off.
// Depends on sdv_pkg, sdv_ifs, sdv_delay, sdv_front, sdv_queue, sdv_back.
`default_nettype none
module stress_divergence_stencil #(
	parameter int MAX_NX      = sdv_pkg::DEF_MAX_NX,
	parameter int MAX_NY      = sdv_pkg::DEF_MAX_NY,
	parameter int MAX_NZ      = sdv_pkg::DEF_MAX_NZ,
	parameter int STRESS_BITS = sdv_pkg::DEF_STRESS_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sdv_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [sdv_pkg::CFG_DATA_W-1:0] cfg_data,
	sdv_site_if.sink                            sites,
	sdv_force_if.source                         forces
);
	import sdv_pkg::*;

	localparam int SB = STRESS_BITS;
	localparam int EW = 18 * SB + 1;

	logic                   solid_q;
	logic [SIZE_X_W-1:0]    size_x_q;
	logic [SIZE_YZ_W-1:0]   size_y_q, size_z_q;
	cfg_t                   cfg;
	front_stat_t            stat;
	logic                   push, pop, q_full, q_nempty, f_last, b_last;
	logic [2:0][2:0][1:0][SB-1:0] f_taps, b_taps;
	logic [$clog2(QDEPTH+1)-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q  <= 1'b0;
			size_x_q <= RST_SIZE_X;
			size_y_q <= RST_SIZE_YZ;
			size_z_q <= RST_SIZE_YZ;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				IDX_SOLID:  solid_q  <= cfg_data[0];
				IDX_SIZE_X: size_x_q <= cfg_data;
				IDX_SIZE_Y: size_y_q <= cfg_data[SIZE_YZ_W-1:0];
				IDX_SIZE_Z: size_z_q <= cfg_data[SIZE_YZ_W-1:0];
				default:    solid_q  <= solid_q;
			endcase
		end
	end

	assign cfg.solid   = solid_q;
	assign cfg.size_x  = size_x_q;
	assign cfg.size_y  = size_y_q;
	assign cfg.size_z  = size_z_q;
	assign cfg.restart = cfg_we && (cfg_idx != IDX_SOLID);

	sdv_front #(.MAX_NX(MAX_NX), .MAX_NY(MAX_NY), .MAX_NZ(MAX_NZ), .STRESS_BITS(SB)) u_front (
		.clk, .arst_n, .cfg, .sites, .q_full, .push, .taps(f_taps), .last(f_last), .stat);

	sdv_queue #(.W(EW)) u_queue (
		.clk, .arst_n, .push, .wdata({f_last, f_taps}), .pop, .rdata({b_last, b_taps}),
		.full(q_full), .nempty(q_nempty), .count(q_count));

	sdv_back #(.STRESS_BITS(SB)) u_back (
		.clk, .arst_n, .nempty(q_nempty), .taps(b_taps), .last(b_last), .pop, .forces);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QDEPTH+1))'(QDEPTH))
		else $error("queue count exceeds depth");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx != IDX_SOLID) |=> stat.pos_origin)
		else $error("size write did not restart frame");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_full && !pop) |-> !push)
		else $error("push into full queue");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(forces.valid) |-> $past(forces.ready))
		else $error("force dropped without transfer");
endmodule
`default_nettype wire
